/* sv/difficulty_target_retarget_defines.svh */
// ----------------------------------------------------------------------------
// difficulty_target_retarget_defines
// assertion macros shared by the retarget block
// ----------------------------------------------------------------------------
`ifndef DIFFICULTY_TARGET_RETARGET_DEFINES_SVH
`define DIFFICULTY_TARGET_RETARGET_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DTR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define DTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/dtr_pkg.sv */
// ----------------------------------------------------------------------------
// dtr_pkg
// types and constants of the difficulty target retarget block
// ----------------------------------------------------------------------------
`default_nettype none
package dtr_pkg;

  localparam int TgtW      = 256;
  localparam int SpanW     = 31;
  localparam int MultW     = 33;
  localparam int ChunkW    = 32;
  localparam int QDepthDef = 2;
  localparam logic [15:0] BlockTimeRst = 16'd600;

  typedef struct packed {
    logic [TgtW-1:0]  target;
    logic [MultW-1:0] mult;
    logic [SpanW-1:0] span;
  } dtr_job_t;

  typedef struct packed {
    logic busy;
    logic done_wait;
  } dtr_back_stat_t;

endpackage
`default_nettype wire

/* sv/dtr_front.sv */
// ----------------------------------------------------------------------------
// dtr_front
// forms the expected span and the clamped elapsed time of one item
// ----------------------------------------------------------------------------
`default_nettype none
module dtr_front (
  input  wire logic [15:0]        block_time,
  input  wire logic [63:0]        old_target_w0,
  input  wire logic [63:0]        old_target_w1,
  input  wire logic [63:0]        old_target_w2,
  input  wire logic [63:0]        old_target_w3,
  input  wire logic [31:0]        start_stamp,
  input  wire logic [31:0]        end_stamp,
  input  wire logic signed [15:0] blk_count,
  output dtr_pkg::dtr_job_t       job
);

  logic [14:0]              cnt;
  logic [dtr_pkg::SpanW-1:0] span_raw;
  logic [dtr_pkg::SpanW-1:0] span;
  logic [31:0]              diff;
  logic [28:0]              lo;
  logic [dtr_pkg::MultW-1:0] hi;
  logic [dtr_pkg::MultW-1:0] mult;

  always_comb begin
    cnt      = (blk_count < 16'sd1) ? 15'd1 : blk_count[14:0];
    span_raw = dtr_pkg::SpanW'(block_time) * dtr_pkg::SpanW'(cnt);
    span     = (span_raw == '0) ? dtr_pkg::SpanW'(1) : span_raw;
    diff     = end_stamp - start_stamp;
    lo       = span[dtr_pkg::SpanW-1:2];
    hi       = {span, 2'b00};
    // negative elapsed time clamps up to the lower bound
    if (diff[31] || (diff < {3'b000, lo})) begin
      mult = dtr_pkg::MultW'(lo);
    end else if ({1'b0, diff} > hi) begin
      mult = hi;
    end else begin
      mult = {1'b0, diff};
    end
    job.target = {old_target_w3, old_target_w2, old_target_w1, old_target_w0};
    job.mult   = mult;
    job.span   = span;
  end

endmodule
`default_nettype wire

/* sv/dtr_queue.sv */
// ----------------------------------------------------------------------------
// dtr_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none
module dtr_queue #(
  parameter int Depth = dtr_pkg::QDepthDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  dtr_pkg::dtr_job_t      wdata,
  output logic                   full,
  input  wire logic              pop,
  output dtr_pkg::dtr_job_t      rdata,
  output logic                   empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  dtr_pkg::dtr_job_t mem [Depth];
  logic [PtrW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CntW'(Depth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PtrW'(Depth - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PtrW'(Depth - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/dtr_back.sv */
// ----------------------------------------------------------------------------
// dtr_back
// multiplies the target by the clamped time and divides by the span
// ----------------------------------------------------------------------------
`default_nettype none
module dtr_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  dtr_pkg::dtr_job_t   job,
  input  wire logic           job_empty,
  output logic                job_pop,
  output logic [63:0]         new_target_w0,
  output logic [63:0]         new_target_w1,
  output logic [63:0]         new_target_w2,
  output logic [63:0]         new_target_w3,
  output logic                res_empty,
  input  wire logic           res_pop,
  output dtr_pkg::dtr_back_stat_t stat
);

  localparam int TgtW   = dtr_pkg::TgtW;
  localparam int ChunkW = dtr_pkg::ChunkW;
  localparam int MultW  = dtr_pkg::MultW;
  localparam int SpanW  = dtr_pkg::SpanW;
  localparam int ProdW  = ChunkW + MultW;
  localparam int MulSteps = TgtW / ChunkW;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_t;

  state_t              state_r;
  logic [TgtW-1:0]     src_r;
  logic [TgtW-1:0]     acc_r;
  logic [MultW-1:0]    mult_r;
  logic [SpanW-1:0]    span_r;
  logic [MultW-1:0]    carry_r;
  logic [SpanW:0]      rem_r;
  logic [7:0]          step_r;
  logic [TgtW-1:0]     res_r;
  logic                res_vld_r;

  logic [ProdW-1:0]    prod;
  logic [SpanW:0]      cur;
  logic                ge;

  assign prod = ProdW'(src_r[ChunkW-1:0]) * ProdW'(mult_r) + ProdW'(carry_r);
  assign cur  = {rem_r[SpanW-1:0], acc_r[TgtW-1]};
  assign ge   = (cur >= {1'b0, span_r});

  assign job_pop   = (state_r == S_IDLE) && !job_empty;
  assign res_empty = !res_vld_r;
  assign {new_target_w3, new_target_w2, new_target_w1, new_target_w0} = res_r;
  assign stat.busy      = (state_r != S_IDLE);
  assign stat.done_wait = (state_r == S_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      res_vld_r <= 1'b0;
      step_r    <= '0;
    end else begin
      if (res_vld_r && res_pop) begin
        res_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!job_empty) begin
            src_r   <= job.target;
            mult_r  <= job.mult;
            span_r  <= job.span;
            carry_r <= '0;
            step_r  <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          // low chunk first, product shifts in from the top
          src_r   <= {{ChunkW{1'b0}}, src_r[TgtW-1:ChunkW]};
          acc_r   <= {prod[ChunkW-1:0], acc_r[TgtW-1:ChunkW]};
          carry_r <= prod[ProdW-1:ChunkW];
          if (step_r == 8'(MulSteps - 1)) begin
            step_r  <= '0;
            rem_r   <= '0;
            state_r <= S_DIV;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_DIV: begin
          // restoring division, quotient bits shift in at the bottom
          rem_r <= ge ? (cur - {1'b0, span_r}) : cur;
          acc_r <= {acc_r[TgtW-2:0], ge};
          if (step_r == 8'(TgtW - 1)) begin
            state_r <= S_DONE;
          end
          step_r <= step_r + 1'b1;
        end
        S_DONE: begin
          if (!res_vld_r) begin
            res_r     <= acc_r;
            res_vld_r <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/difficulty_target_retarget.sv */
// ----------------------------------------------------------------------------
// difficulty_target_retarget
// rescales a 256-bit target by clamped elapsed time over expected span
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  input     in_* fields, in_push/in_full  beat when push & !full
//  result    out_* fields, out_pop/empty   beat when pop & !empty
//  config    cfg_we, cfg_block_time_seconds write when we
//
//  front stage classifies combinationally and pushes into a queue
//  the back unit multiplies chunk by chunk, then divides bit by bit,
//  one item at a time; the restoring divider sets the rate
//  input stays open while the queue has room, also while a result waits
//  synchronous active-low reset; block time resets to 600
// ----------------------------------------------------------------------------
`default_nettype none
`include "difficulty_target_retarget_defines.svh"
module difficulty_target_retarget #(
  parameter int QDepth = dtr_pkg::QDepthDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_block_time_seconds,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [63:0]        in_old_target_w0,
  input  wire logic [63:0]        in_old_target_w1,
  input  wire logic [63:0]        in_old_target_w2,
  input  wire logic [63:0]        in_old_target_w3,
  input  wire logic [31:0]        in_start_stamp,
  input  wire logic [31:0]        in_end_stamp,
  input  wire logic signed [15:0] in_blk_count,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [63:0]             out_new_target_w0,
  output logic [63:0]             out_new_target_w1,
  output logic [63:0]             out_new_target_w2,
  output logic [63:0]             out_new_target_w3
);

  logic [15:0]             bt_r;
  dtr_pkg::dtr_job_t       fjob, qjob;
  logic                    q_empty, q_pop;
  dtr_pkg::dtr_back_stat_t bstat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bt_r <= dtr_pkg::BlockTimeRst;
    end else if (cfg_we) begin
      bt_r <= cfg_block_time_seconds;
    end
  end

  dtr_front u_front (
    .block_time     (bt_r),
    .old_target_w0  (in_old_target_w0),
    .old_target_w1  (in_old_target_w1),
    .old_target_w2  (in_old_target_w2),
    .old_target_w3  (in_old_target_w3),
    .start_stamp    (in_start_stamp),
    .end_stamp      (in_end_stamp),
    .blk_count      (in_blk_count),
    .job            (fjob)
  );

  dtr_queue #(.Depth(QDepth)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (fjob),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (qjob),
    .empty (q_empty)
  );

  dtr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job           (qjob),
    .job_empty     (q_empty),
    .job_pop       (q_pop),
    .new_target_w0 (out_new_target_w0),
    .new_target_w1 (out_new_target_w1),
    .new_target_w2 (out_new_target_w2),
    .new_target_w3 (out_new_target_w3),
    .res_empty     (out_empty),
    .res_pop       (out_pop),
    .stat          (bstat)
  );

  `DTR_ASSERT_NOW(a_pop_idle, q_pop, !bstat.busy && !q_empty, "job taken while back busy")
  `DTR_ASSERT_NEXT(a_res_hold, !out_empty && !out_pop, !out_empty, "result lost without pop")
  `DTR_ASSERT_NEXT(a_busy_after_pop, q_pop, bstat.busy, "back did not start after taking a job")
  `DTR_ASSERT_NOW(a_wait_full, bstat.done_wait && !$past(bstat.done_wait) && $past(rst_n),
                  $past(bstat.busy), "back finished without working")

endmodule
`default_nettype wire
